[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Thin wrappers around concurrent assertions; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/psep_pkg.sv]
// ----------------------------------------------------------------------------
// psep_pkg
// Types and constants shared by the archive stream entry parser.
// ----------------------------------------------------------------------------
package psep_pkg;

	localparam int unsigned SIZE_W             = 56;
	localparam int unsigned CNT_W              = 4;
	localparam int unsigned SIZE_BYTES_MAX     = 8;
	localparam int unsigned MESH_PAYLOAD_BYTES = 12;
	localparam int unsigned MAGIC_LEN          = 4;

	localparam logic [7:0] MAGIC_WORD [MAGIC_LEN] = '{8'h56, 8'h55, 8'h4C, 8'h4C};

	// parse phases
	localparam logic [3:0] PH_MAGIC       = 4'd0;
	localparam logic [3:0] PH_COUNT       = 4'd1;
	localparam logic [3:0] PH_TYPE        = 4'd2;
	localparam logic [3:0] PH_SIZE        = 4'd3;
	localparam logic [3:0] PH_MESH_NAME   = 4'd4;
	localparam logic [3:0] PH_SHADER_NAME = 4'd5;
	localparam logic [3:0] PH_PAYLOAD     = 4'd6;
	localparam logic [3:0] PH_DONE        = 4'd7;
	localparam logic [3:0] PH_ERROR       = 4'd8;

	// byte kinds
	localparam logic [3:0] KIND_MAGIC   = 4'd0;
	localparam logic [3:0] KIND_COUNT   = 4'd1;
	localparam logic [3:0] KIND_TYPE    = 4'd2;
	localparam logic [3:0] KIND_SIZE    = 4'd3;
	localparam logic [3:0] KIND_NAME    = 4'd4;
	localparam logic [3:0] KIND_TERM    = 4'd5;
	localparam logic [3:0] KIND_PAYLOAD = 4'd6;
	localparam logic [3:0] KIND_IGNORED = 4'd7;
	localparam logic [3:0] KIND_ERROR   = 4'd8;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_MAGIC     = 2'd1;
	localparam logic [1:0] ERR_EARLY_END = 2'd2;
	localparam logic [1:0] ERR_UNDERFLOW = 2'd3;

	// register indexes
	localparam logic [0:0] REG_MESH_TYPE   = 1'd0;
	localparam logic [0:0] REG_SHADER_TYPE = 1'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_last;
	} item_t;

	typedef struct packed {
		logic [3:0]        byte_kind;
		logic [7:0]        byte_echo;
		logic [7:0]        current_type;
		logic [15:0]       entry_number;
		logic [SIZE_W-1:0] decoded_size;
		logic [SIZE_W-1:0] payload_length;
		logic              entry_complete;
		logic              all_done;
		logic [1:0]        error_code;
	} result_t;

	typedef struct packed {
		logic [3:0]        phase;
		logic [CNT_W-1:0]  field_cnt;
		logic [15:0]       entries_total;
		logic [15:0]       entries_seen;
		logic [7:0]        type_held;
		logic [SIZE_W-1:0] size_acc;
		logic [SIZE_W-1:0] name_left;
		logic [SIZE_W-1:0] payload_left;
		logic [SIZE_W-1:0] payload_total;
		logic [1:0]        sticky_err;
	} state_t;

endpackage

[sv/psep_chan_if.sv]
// ----------------------------------------------------------------------------
// psep_chan_if
// Valid/ready channel carrying one payload struct per request.
// ----------------------------------------------------------------------------
interface psep_chan_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[sv/pack_stream_entry_parser_top.sv]
// ----------------------------------------------------------------------------
// pack_stream_entry_parser_top: archive byte stream entry parser
// Each byte passes the input register, then the result register. One byte per cycle
// sustained while out_ch.ready holds, set by the single-step parse logic between them.
// Reset (arst_n low, async) returns to the magic phase with no error pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pack_stream_entry_parser_top import psep_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	psep_chan_if.sink     in_ch,
	psep_chan_if.source   out_ch,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [7:0]    cfg_wdata
);

	// Configuration registers: the type codes that select mesh and shader
	// handling. The user must write them only while the parser is idle; the block does not enforce it.
	logic [7:0] mesh_code_q;
	logic [7:0] shader_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_code_q   <= 8'd2;
			shader_code_q <= 8'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MESH_TYPE:   mesh_code_q   <= cfg_wdata;
				REG_SHADER_TYPE: shader_code_q <= cfg_wdata;
				default:         mesh_code_q   <= mesh_code_q;
			endcase
		end
	end

	// Input register stage. A byte waits here until the result register has
	// room; it is only then that the parse step runs and the parser state
	// moves, so stalls on the output never disturb the state.
	logic  valid_s1;
	item_t item_s1;

	// Result register and its valid flag.
	logic    out_valid_q;
	result_t result_q;

	// Parser state, updated once per byte that moves into the result reg.
	state_t state_q;
	state_t state_nxt;
	result_t result_nxt;

	logic advance;
	logic in_take;

	// A byte advances when the result register is empty or is being drained
	// this cycle; the input side stays open whenever stage one moves on.
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_take     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_ch.payload;
		end
	end

	psep_step u_step (
		.cur         (state_q),
		.mesh_code   (mesh_code_q),
		.shader_code (shader_code_q),
		.item        (item_s1),
		.nxt         (state_nxt),
		.res         (result_nxt)
	);

	// Control and size state all sit in one struct; everything resets to
	// the magic phase with cleared counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				phase:         PH_MAGIC,
				field_cnt:     '0,
				entries_total: '0,
				entries_seen:  '0,
				type_held:     '0,
				size_acc:      '0,
				name_left:     '0,
				payload_left:  '0,
				payload_total: '0,
				sticky_err:    ERR_NONE
			};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = result_q;

	// Short names for the checks below.
	logic chk_err;
	logic chk_done;
	logic chk_seen_all;
	logic chk_end;
	logic chk_end_kind;

	assign chk_err      = (state_q.phase == PH_ERROR);
	assign chk_done     = (state_q.phase == PH_DONE);
	assign chk_seen_all = (state_q.entries_seen == state_q.entries_total);
	assign chk_end      = out_valid_q && result_q.entry_complete;
	assign chk_end_kind = (result_q.byte_kind == KIND_SIZE) || (result_q.byte_kind == KIND_TERM)
		|| (result_q.byte_kind == KIND_PAYLOAD);

	// Error phase is terminal and always carries a nonzero code.
	`ASSERT_IMPLIES(a_err_has_code, clk, arst_n, chk_err, state_q.sticky_err != ERR_NONE)
	`ASSERT_NEXT(a_err_sticky, clk, arst_n, chk_err, chk_err)
	// Done only once every counted entry has been seen.
	`ASSERT_IMPLIES(a_done_count, clk, arst_n, chk_done, chk_seen_all)
	// An entry can only end on a size, terminator or payload byte.
	`ASSERT_IMPLIES(a_complete_kind, clk, arst_n, chk_end, chk_end_kind)

endmodule

[sv/psep_step.sv]
// ----------------------------------------------------------------------------
// psep_step
// Per-byte parse step: next parser state and the byte's classification.
// ----------------------------------------------------------------------------
module psep_step import psep_pkg::*; (
	input  state_t     cur,
	input  logic [7:0] mesh_code,
	input  logic [7:0] shader_code,
	input  item_t      item,
	output state_t     nxt,
	output result_t    res
);

	logic [7:0]        b;
	logic [3:0]        kind;
	logic              complete;
	logic [1:0]        err;
	logic [CNT_W-1:0]  cnt_inc;
	logic [5:0]        shamt;
	logic [SIZE_W-1:0] size_or;
	logic [SIZE_W-1:0] acc_new;
	logic [SIZE_W-1:0] mesh_rem;
	logic [SIZE_W-1:0] name_dec;
	logic [SIZE_W-1:0] pay_dec;
	logic [15:0]       seen_inc;

	assign b        = item.data_byte;
	assign cnt_inc  = cur.field_cnt + CNT_W'(1);
	assign shamt    = {3'b000, cur.field_cnt[2:0]} * 6'd7;
	assign size_or  = SIZE_W'({1'b0, b[6:0]}) << shamt;
	assign acc_new  = cur.size_acc | size_or;
	assign mesh_rem = acc_new - SIZE_W'(MESH_PAYLOAD_BYTES);
	assign name_dec = cur.name_left - SIZE_W'(1);
	assign pay_dec  = cur.payload_left - SIZE_W'(1);
	assign seen_inc = cur.entries_seen + 16'd1;

	always_comb begin
		nxt      = cur;
		kind     = KIND_IGNORED;
		complete = 1'b0;
		err      = ERR_NONE;

		unique case (cur.phase)
			PH_MAGIC: begin
				kind = KIND_MAGIC;
				if (b != MAGIC_WORD[cur.field_cnt[1:0]]) begin
					err = ERR_MAGIC;
				end else if (cnt_inc >= CNT_W'(MAGIC_LEN)) begin
					nxt.field_cnt = '0;
					nxt.phase     = PH_COUNT;
				end else begin
					nxt.field_cnt = cnt_inc;
				end
			end
			PH_COUNT: begin
				kind = KIND_COUNT;
				if (cur.field_cnt == '0) begin
					nxt.entries_total = {8'h00, b};
					nxt.field_cnt     = CNT_W'(1);
				end else begin
					nxt.entries_total = {b, cur.entries_total[7:0]};
					nxt.field_cnt     = '0;
					nxt.entries_seen  = '0;
					nxt.phase = ({b, cur.entries_total[7:0]} == 16'd0) ? PH_DONE : PH_TYPE;
				end
			end
			PH_TYPE: begin
				kind              = KIND_TYPE;
				nxt.type_held     = b;
				nxt.size_acc      = '0;
				nxt.name_left     = '0;
				nxt.payload_left  = '0;
				nxt.payload_total = '0;
				nxt.field_cnt     = '0;
				nxt.phase         = PH_SIZE;
			end
			PH_SIZE: begin
				kind          = KIND_SIZE;
				nxt.size_acc  = acc_new;
				nxt.field_cnt = cnt_inc;
				if (!b[7] || cnt_inc >= CNT_W'(SIZE_BYTES_MAX)) begin
					nxt.field_cnt = '0;
					if (cur.type_held == mesh_code) begin
						if (acc_new < SIZE_W'(MESH_PAYLOAD_BYTES)) begin
							err = ERR_UNDERFLOW;
						end else begin
							nxt.name_left     = mesh_rem;
							nxt.payload_total = SIZE_W'(MESH_PAYLOAD_BYTES);
							nxt.payload_left  = SIZE_W'(MESH_PAYLOAD_BYTES);
							nxt.phase = (mesh_rem != '0) ? PH_MESH_NAME : PH_PAYLOAD;
						end
					end else if (cur.type_held == shader_code) begin
						nxt.name_left = acc_new;
						nxt.phase     = PH_SHADER_NAME;
					end else begin
						nxt.payload_total = acc_new;
						nxt.payload_left  = acc_new;
						if (acc_new == '0) begin
							complete = 1'b1;
						end else begin
							nxt.phase = PH_PAYLOAD;
						end
					end
				end
			end
			PH_MESH_NAME: begin
				kind = KIND_NAME;
				if (cur.name_left != '0) begin
					nxt.name_left = name_dec;
				end
				if (cur.name_left == '0 || name_dec == '0) begin
					nxt.phase = PH_PAYLOAD;
				end
			end
			PH_SHADER_NAME: begin
				if (cur.name_left == '0) begin
					err = ERR_UNDERFLOW;
				end else begin
					nxt.name_left = name_dec;
					if (b == 8'h00) begin
						kind              = KIND_TERM;
						nxt.payload_total = name_dec;
						nxt.payload_left  = name_dec;
						if (name_dec == '0) begin
							complete = 1'b1;
						end else begin
							nxt.phase = PH_PAYLOAD;
						end
					end else begin
						kind = KIND_NAME;
					end
				end
			end
			PH_PAYLOAD: begin
				kind = KIND_PAYLOAD;
				if (cur.payload_left != '0) begin
					nxt.payload_left = pay_dec;
				end
				if (cur.payload_left == '0 || pay_dec == '0) begin
					complete = 1'b1;
				end
			end
			PH_DONE: begin
				kind = KIND_IGNORED;
			end
			default: begin
				kind      = KIND_ERROR;
				nxt.phase = PH_ERROR;
			end
		endcase

		if (complete) begin
			nxt.entries_seen = seen_inc;
			nxt.phase = (seen_inc == cur.entries_total) ? PH_DONE : PH_TYPE;
		end

		priority if (err != ERR_NONE) begin
			nxt.sticky_err = err;
			nxt.phase      = PH_ERROR;
			kind           = KIND_ERROR;
			complete       = 1'b0;
		end else if (item.stream_last && nxt.phase != PH_DONE && nxt.phase != PH_ERROR) begin
			nxt.sticky_err = ERR_EARLY_END;
			nxt.phase      = PH_ERROR;
		end else begin
			nxt.sticky_err = nxt.sticky_err;
		end

		res.byte_kind      = kind;
		res.byte_echo      = b;
		res.current_type   = nxt.type_held;
		res.entry_number   = nxt.entries_seen;
		res.decoded_size   = nxt.size_acc;
		res.payload_length = nxt.payload_total;
		res.entry_complete = complete;
		res.all_done       = (nxt.phase == PH_DONE);
		res.error_code     = nxt.sticky_err;
	end

endmodule

[tb/sv/pack_stream_parse_monitor.sv]
// ----------------------------------------------------------------------------
// pack_stream_parse_monitor
// Watches the byte and result channels of the archive stream parser, keeps
// its own copy of the parse state and compares every result field by field.
// ----------------------------------------------------------------------------
module pack_stream_parse_monitor import psep_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_ready,
	input  item_t      req_item,
	input  logic       res_valid,
	input  logic       res_ready,
	input  result_t    res_item,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	output int         mismatch_total,
	output int         results_owed
);

	// parse state
	logic [3:0]        phase;
	logic [3:0]        field_cnt;
	logic [15:0]       count_total;
	logic [15:0]       count_done;
	logic [7:0]        type_held;
	logic [SIZE_W-1:0] size_acc;
	logic [SIZE_W-1:0] name_left;
	logic [SIZE_W-1:0] pay_left;
	logic [SIZE_W-1:0] pay_total;
	logic [1:0]        sticky_err;
	logic [7:0]        mesh_code;
	logic [7:0]        shader_code;

	result_t expected_results[$];
	result_t want;

	task automatic open_payload(input logic [SIZE_W-1:0] len, inout logic fin);
		pay_total = len;
		pay_left  = len;
		if (len == 0)
			fin = 1'b1;
		else
			phase = PH_PAYLOAD;
	endtask

	// next result for one stream byte; advances the parse state
	task automatic classify_byte(input item_t it, output result_t r);
		logic [7:0]  b;
		logic [3:0]  kind;
		logic        fin;
		logic [1:0]  err;
		logic [63:0] chunk;
		b    = it.data_byte;
		kind = KIND_IGNORED;
		fin  = 1'b0;
		err  = ERR_NONE;
		case (phase)
			PH_MAGIC: begin
				kind = KIND_MAGIC;
				if (b != MAGIC_WORD[field_cnt[1:0]]) begin
					err = ERR_MAGIC;
				end else begin
					field_cnt = field_cnt + 4'd1;
					if (field_cnt >= MAGIC_LEN) begin
						field_cnt = 0;
						phase = PH_COUNT;
					end
				end
			end
			PH_COUNT: begin
				kind = KIND_COUNT;
				if (field_cnt == 0) begin
					count_total = {8'h00, b};
					field_cnt = 1;
				end else begin
					count_total[15:8] = b;
					field_cnt = 0;
					count_done = 0;
					phase = (count_total == 0) ? PH_DONE : PH_TYPE;
				end
			end
			PH_TYPE: begin
				kind = KIND_TYPE;
				type_held = b;
				size_acc  = 0;
				name_left = 0;
				pay_left  = 0;
				pay_total = 0;
				field_cnt = 0;
				phase = PH_SIZE;
			end
			PH_SIZE: begin
				kind = KIND_SIZE;
				chunk = 64'(b[6:0]) << (7 * int'(field_cnt));
				size_acc = size_acc | chunk[SIZE_W-1:0];
				field_cnt = field_cnt + 4'd1;
				if (!b[7] || field_cnt >= SIZE_BYTES_MAX) begin
					field_cnt = 0;
					// mesh takes precedence when both codes match
					if (type_held == mesh_code) begin
						if (size_acc < MESH_PAYLOAD_BYTES) begin
							err = ERR_UNDERFLOW;
						end else begin
							name_left = size_acc - SIZE_W'(MESH_PAYLOAD_BYTES);
							pay_total = SIZE_W'(MESH_PAYLOAD_BYTES);
							pay_left  = pay_total;
							phase = (name_left != 0) ? PH_MESH_NAME : PH_PAYLOAD;
						end
					end else if (type_held == shader_code) begin
						name_left = size_acc;
						phase = PH_SHADER_NAME;
					end else begin
						open_payload(size_acc, fin);
					end
				end
			end
			PH_MESH_NAME: begin
				kind = KIND_NAME;
				if (name_left != 0)
					name_left = name_left - SIZE_W'(1);
				if (name_left == 0)
					phase = PH_PAYLOAD;
			end
			PH_SHADER_NAME: begin
				if (name_left == 0) begin
					err = ERR_UNDERFLOW;
				end else begin
					name_left = name_left - SIZE_W'(1);
					if (b == 8'h00) begin
						kind = KIND_TERM;
						open_payload(name_left, fin);
					end else begin
						kind = KIND_NAME;
					end
				end
			end
			PH_PAYLOAD: begin
				kind = KIND_PAYLOAD;
				if (pay_left != 0)
					pay_left = pay_left - SIZE_W'(1);
				if (pay_left == 0)
					fin = 1'b1;
			end
			PH_DONE: begin
				kind = KIND_IGNORED;
			end
			default: begin
				kind = KIND_ERROR;
				phase = PH_ERROR;
			end
		endcase

		if (fin) begin
			count_done = count_done + 16'd1;
			phase = (count_done == count_total) ? PH_DONE : PH_TYPE;
		end

		if (err != ERR_NONE) begin
			sticky_err = err;
			phase = PH_ERROR;
			kind = KIND_ERROR;
			fin = 1'b0;
		end else if (it.stream_last && phase != PH_DONE && phase != PH_ERROR) begin
			sticky_err = ERR_EARLY_END;
			phase = PH_ERROR;
		end

		r.byte_kind      = kind;
		r.byte_echo      = b;
		r.current_type   = type_held;
		r.entry_number   = count_done;
		r.decoded_size   = size_acc;
		r.payload_length = pay_total;
		r.entry_complete = fin;
		r.all_done       = (phase == PH_DONE);
		r.error_code     = sticky_err;
	endtask

	task automatic check_field(input string label, input logic [SIZE_W-1:0] exp_v,
			input logic [SIZE_W-1:0] act_v);
		if (exp_v !== act_v) begin
			mismatch_total++;
			$display("%0t %s: expected %0h, actual %0h", $time, label, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase       = PH_MAGIC;
			field_cnt   = 0;
			count_total = 0;
			count_done  = 0;
			type_held   = 0;
			size_acc    = 0;
			name_left   = 0;
			pay_left    = 0;
			pay_total   = 0;
			sticky_err  = ERR_NONE;
			mesh_code   = 8'd2;
			shader_code = 8'd3;
			expected_results.delete();
			results_owed   = 0;
			mismatch_total = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MESH_TYPE)
					mesh_code = cfg_wdata;
				else
					shader_code = cfg_wdata;
			end
			// result side first: a request accepted on this edge cannot have its result yet
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					mismatch_total++;
					$display("%0t result with nothing outstanding: expected none, actual %0h",
						$time, res_item);
				end else begin
					want = expected_results.pop_front();
					check_field("byte_kind", SIZE_W'(want.byte_kind),
						SIZE_W'(res_item.byte_kind));
					check_field("byte_echo", SIZE_W'(want.byte_echo),
						SIZE_W'(res_item.byte_echo));
					check_field("current_type", SIZE_W'(want.current_type),
						SIZE_W'(res_item.current_type));
					check_field("entry_number", SIZE_W'(want.entry_number),
						SIZE_W'(res_item.entry_number));
					check_field("decoded_size", want.decoded_size, res_item.decoded_size);
					check_field("payload_length", want.payload_length, res_item.payload_length);
					check_field("entry_complete", SIZE_W'(want.entry_complete),
						SIZE_W'(res_item.entry_complete));
					check_field("all_done", SIZE_W'(want.all_done),
						SIZE_W'(res_item.all_done));
					check_field("error_code", SIZE_W'(want.error_code),
						SIZE_W'(res_item.error_code));
				end
			end
			if (req_valid && req_ready) begin
				classify_byte(req_item, want);
				expected_results.push_back(want);
			end
			results_owed = expected_results.size();
		end
	end

endmodule

[tb/sv/tb_pack_stream_entry_parser_top.sv]
// ----------------------------------------------------------------------------
// tb_pack_stream_entry_parser_top
// Feeds one archive stream through the parser: a directed header, well-formed
// entries of every kind under several type-code settings, then one ending
// (clean finish, early end, or a size underflow) followed by trailing noise.
// A rare run breaks the magic or declares no entries. The monitor predicts
// and checks every result; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_pack_stream_entry_parser_top;
	import psep_pkg::*;

	localparam int QUIET_LIMIT = 1000;  // cycles without any request moving
	localparam int N_SETTINGS  = 5;

	typedef enum int {RUN_BAD_MAGIC, RUN_NO_ENTRIES, RUN_ARCHIVE} run_e;
	typedef enum int {END_DONE, END_EARLY, END_MESH_SHORT, END_SHADER_SHORT} ending_e;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_wdata;
	int         mismatch_total;
	int         results_owed;
	int         quiet_cycles = 0;

	// type codes currently loaded, used to build consistent entries
	logic [7:0] mesh_code;
	logic [7:0] shader_code;

	item_t stream_q[$];

	// receiver stall pattern
	int rx_mode = 0;
	int rx_left = 0;

	psep_chan_if #(.payload_t(item_t))   in_ch ();
	psep_chan_if #(.payload_t(result_t)) out_ch ();

	pack_stream_entry_parser_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	pack_stream_parse_monitor parse_mon (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (in_ch.valid),
		.req_ready      (in_ch.ready),
		.req_item       (in_ch.payload),
		.res_valid      (out_ch.valid),
		.res_ready      (out_ch.ready),
		.res_item       (out_ch.payload),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatch_total (mismatch_total),
		.results_owed   (results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: stretches of steady ready, coin-flip ready, rare stalls, or a
	// solid stall, each of random length.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = (rx_mode == 3) ? $urandom_range(1, 12) : $urandom_range(8, 64);
		end
		rx_left--;
		case (rx_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= 1'($urandom_range(0, 1));
			2: out_ch.ready <= ($urandom_range(0, 7) != 0);
			default: out_ch.ready <= 1'b0;
		endcase
	end

	// Watchdog: any request moving on either channel resets the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic put_byte(input logic [7:0] b);
		stream_q.push_back('{data_byte: b, stream_last: 1'b0});
	endtask

	// junk after the stream has ended; stream_last toggles freely here
	task automatic put_noise(input int n);
		repeat (n) stream_q.push_back('{data_byte: 8'($urandom), stream_last: 1'($urandom)});
	endtask

	// Size varint: mostly minimal, sometimes padded with empty groups, sometimes
	// stretched to the full byte limit with the continuation bit never cleared.
	task automatic put_varint(input logic [SIZE_W-1:0] value);
		int          groups;
		int          total;
		int          style;
		logic [SIZE_W-1:0] v;
		groups = 1;
		v = value >> 7;
		while (v != 0) begin
			groups++;
			v = v >> 7;
		end
		style = $urandom_range(0, 9);
		if (style == 9)
			total = SIZE_BYTES_MAX;
		else if (style >= 7)
			total = $urandom_range(groups, SIZE_BYTES_MAX);
		else
			total = groups;
		v = value;
		for (int i = 0; i < total; i++) begin
			put_byte({(style == 9) || (i != total - 1), v[6:0]});
			v = v >> 7;
		end
	endtask

	// One complete entry whose layout follows the codes now loaded.
	task automatic put_entry();
		logic [7:0] t_byte;
		int         pick;
		int         name_len;
		int         pay_len;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			t_byte = mesh_code;
		end else if (pick < 6) begin
			t_byte = shader_code;
		end else begin
			do t_byte = 8'($urandom_range(0, 255));
			while (t_byte == mesh_code || t_byte == shader_code);
		end
		put_byte(t_byte);
		if (t_byte == mesh_code) begin
			name_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
				: $urandom_range(0, 5);
			put_varint(SIZE_W'(name_len + MESH_PAYLOAD_BYTES));
			repeat (name_len) put_byte(8'($urandom));
			repeat (MESH_PAYLOAD_BYTES) put_byte(8'($urandom));
		end else if (t_byte == shader_code) begin
			name_len = $urandom_range(0, 6);
			pay_len  = $urandom_range(0, 8);
			put_varint(SIZE_W'(name_len + 1 + pay_len));
			repeat (name_len) put_byte(8'($urandom_range(1, 255)));
			put_byte(8'h00);
			repeat (pay_len) put_byte(8'($urandom));
		end else begin
			pay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 160)
				: $urandom_range(0, 10);
			put_varint(SIZE_W'(pay_len));
			repeat (pay_len) put_byte(8'($urandom));
		end
	endtask

	// Drive the queued bytes in bursts. A zero gap keeps valid high into the
	// next burst. Ready is sampled at the falling edge, once it has settled.
	task automatic send_stream();
		int   burst;
		int   gap;
		logic took;
		while (stream_q.size() != 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && stream_q.size() != 0) begin
				in_ch.valid   <= 1'b1;
				in_ch.payload <= stream_q.pop_front();
				do begin
					@(negedge clk);
					took = in_ch.ready;
					@(posedge clk);
				end while (!took);
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_ch.valid <= 1'b0;
	endtask

	// Hold off until every request has its result, then a few spare cycles.
	task automatic settle();
		do @(negedge clk); while (results_owed != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_type_codes(input logic [7:0] m, input logic [7:0] s);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MESH_TYPE;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_index <= REG_SHADER_TYPE;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		mesh_code   = m;
		shader_code = s;
		@(posedge clk);
	endtask

	// reset codes, both extremes each way, equal codes, random distinct codes
	task automatic load_setting(input int p);
		logic [7:0] m;
		case (p)
			0: load_type_codes(8'd2, 8'd3);
			1: load_type_codes(8'd0, 8'd255);
			2: load_type_codes(8'd255, 8'd0);
			3: begin
				m = 8'($urandom);
				load_type_codes(m, m);
			end
			default: begin
				m = 8'($urandom);
				load_type_codes(m, m ^ 8'($urandom_range(1, 255)));
			end
		endcase
	endtask

	initial begin
		run_e       run;
		ending_e    ending;
		int         roll;
		int         n_entries;
		int         keep;
		int         good;
		logic [7:0] b;
		logic [15:0] hdr_count;

		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.payload = '0;
		out_ch.ready  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_MESH_TYPE;
		cfg_wdata     = 8'd0;
		mesh_code     = 8'd2;
		shader_code   = 8'd3;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		roll = $urandom_range(0, 15);
		run  = (roll == 0) ? RUN_BAD_MAGIC : (roll == 1) ? RUN_NO_ENTRIES : RUN_ARCHIVE;
		load_setting(0);

		if (run != RUN_ARCHIVE) begin
			// Short run: the stream dies or finishes in its header; the rest is
			// trailing bytes spread over every code setting.
			if (run == RUN_BAD_MAGIC) begin
				good = $urandom_range(0, MAGIC_LEN - 1);
				for (int i = 0; i < good; i++)
					put_byte(MAGIC_WORD[i]);
				do b = 8'($urandom); while (b == MAGIC_WORD[good]);
				put_byte(b);
			end else begin
				for (int i = 0; i < MAGIC_LEN; i++)
					put_byte(MAGIC_WORD[i]);
				put_byte(8'h00);
				put_byte(8'h00);
			end
			send_stream();
			for (int p = 0; p < N_SETTINGS; p++) begin
				settle();
				load_setting(p);
				put_noise(220);
				send_stream();
			end
		end else begin
			ending    = ending_e'($urandom_range(0, 3));
			n_entries = N_SETTINGS * $urandom_range(12, 18);
			// a clean finish needs the exact count; otherwise keep it out of reach
			if (ending == END_DONE)
				hdr_count = 16'(n_entries + 3);
			else
				hdr_count = 16'($urandom_range(n_entries + 5, 65535));

			// Directed header and three short entries under the reset codes:
			// other type with zero size (completes on its size byte), shader
			// whose payload is empty (completes on the terminator), and other
			// type with a full-length size that keeps bit 7 set throughout.
			for (int i = 0; i < MAGIC_LEN; i++)
				put_byte(MAGIC_WORD[i]);
			put_byte(hdr_count[7:0]);
			put_byte(hdr_count[15:8]);
			put_byte(8'h00);
			put_byte(8'h00);
			put_byte(shader_code);
			put_byte(8'h02);
			put_byte(8'h61);
			put_byte(8'h00);
			put_byte(8'hFF);
			put_byte(8'h81);
			repeat (SIZE_BYTES_MAX - 1) put_byte(8'h80);
			put_byte(8'h7E);
			send_stream();

			// Well-formed entries; codes change only while nothing is in flight.
			for (int p = 0; p < N_SETTINGS; p++) begin
				settle();
				load_setting(p);
				repeat (n_entries / N_SETTINGS) put_entry();
				send_stream();
			end
			settle();

			case (ending)
				END_EARLY: begin
					if ($urandom_range(0, 1) == 0) begin
						// end the stream anywhere inside a normal entry, possibly on its last byte
						put_entry();
						keep = $urandom_range(1, stream_q.size());
						while (stream_q.size() > keep)
							void'(stream_q.pop_back());
					end else begin
						// huge size that uses every size bit, then a few payload bytes
						do b = 8'($urandom); while (b == mesh_code || b == shader_code);
						put_byte(b);
						repeat (SIZE_BYTES_MAX) put_byte(8'($urandom) | 8'h80);
						repeat ($urandom_range(0, 5)) put_byte(8'($urandom));
					end
					stream_q[stream_q.size() - 1].stream_last = 1'b1;
				end
				END_MESH_SHORT: begin
					put_byte(mesh_code);
					put_varint(SIZE_W'($urandom_range(0, MESH_PAYLOAD_BYTES - 1)));
				end
				END_SHADER_SHORT: begin
					// name runs past the size; the extra byte may be the terminator
					put_byte(shader_code);
					keep = $urandom_range(0, 5);
					put_varint(SIZE_W'(keep));
					repeat (keep) put_byte(8'($urandom_range(1, 255)));
					put_byte(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
				end
				default: ;
			endcase
			// after done or after an error every further byte is classified the same
			put_noise(24);
			send_stream();
		end

		settle();
		repeat (4) @(posedge clk);
		if (mismatch_total == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/psep_pkg.sv
sv/psep_chan_if.sv
sv/psep_step.sv
sv/pack_stream_entry_parser_top.sv
tb/sv/pack_stream_parse_monitor.sv
tb/sv/tb_pack_stream_entry_parser_top.sv
